### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the numeric literal scanner.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// expr must hold at every clock edge outside reset
`define AST_HOLDS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// whenever pre holds, post must hold at the next edge
`define AST_NEXT(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define AST_HOLDS(lbl, clk, rst, expr, msg)
`define AST_NEXT(lbl, clk, rst, pre, post, msg)
`endif

`endif

### rtl/nls_pkg.sv
// Types, codes and character helpers for the numeric literal scanner.
// No dependencies.
`timescale 1ns / 1ps

package nls_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ZERO,
    PH_INT,
    PH_DOT,
    PH_FRAC,
    PH_SKIP_INT,
    PH_SKIP_FRAC
  } phase_t;

  typedef enum logic [1:0] {
    BASE_DEC,
    BASE_BIN,
    BASE_OCT,
    BASE_HEX
  } base_t;

  typedef enum logic [1:0] {
    KIND_INT,
    KIND_REAL,
    KIND_BAD_INT,
    KIND_BAD_REAL
  } kind_t;

  localparam logic [1:0] REPLAY_ONE = 2'd1;
  localparam logic [1:0] REPLAY_TWO = 2'd2;

  localparam logic [7:0] CH_UNDER = 8'h5F;  // '_'
  localparam logic [7:0] CH_DOT   = 8'h2E;  // '.'
  localparam logic [7:0] CH_B     = 8'h62;  // 'b'
  localparam logic [7:0] CH_O     = 8'h6F;  // 'o'
  localparam logic [7:0] CH_D     = 8'h64;  // 'd'
  localparam logic [7:0] CH_X     = 8'h78;  // 'x'
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LZ    = 8'h7A;

  typedef struct packed {
    logic [7:0] ch;
    logic       first;
  } char_word_t;

  typedef struct packed {
    kind_t              kind;
    logic [4:0]         radix;
    logic signed [31:0] int_value;
    logic signed [31:0] frac_value;
    logic [7:0]         frac_places;
    logic [1:0]         replay;
  } tok_word_t;

  function automatic logic [4:0] radix_of(base_t b);
    unique case (b)
      BASE_BIN: radix_of = 5'd2;
      BASE_OCT: radix_of = 5'd8;
      BASE_HEX: radix_of = 5'd16;
      default:  radix_of = 5'd10;
    endcase
  endfunction

  function automatic logic is_dec(logic [7:0] c);
    is_dec = (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_alnum(logic [7:0] c);
    is_alnum = is_dec(c) || ((c >= CH_LA) && (c <= CH_LZ)) ||
               ((c >= CH_UA) && (c <= CH_UZ));
  endfunction

  // {valid, value} of c as a digit of base b
  function automatic logic [4:0] digit_of(base_t b, logic [7:0] c);
    logic [7:0] lo;
    logic [7:0] ua;
    logic [7:0] la;
    lo = c - CH_0;
    ua = c - CH_UA + 8'd10;
    la = c - CH_LA + 8'd10;
    digit_of = 5'd0;
    unique case (b)
      BASE_BIN: if ((c | 8'h01) == CH_1) digit_of = {1'b1, lo[3:0]};
      BASE_OCT: if ((c | 8'h07) == CH_7) digit_of = {1'b1, lo[3:0]};
      BASE_HEX: begin
        if (is_dec(c)) digit_of = {1'b1, lo[3:0]};
        else if ((c >= CH_UA) && (c <= CH_UF)) digit_of = {1'b1, ua[3:0]};
        else if ((c >= CH_LA) && (c <= CH_LF)) digit_of = {1'b1, la[3:0]};
      end
      default: if (is_dec(c)) digit_of = {1'b1, lo[3:0]};
    endcase
  endfunction

endpackage

### rtl/number_literal_scanner.sv
// Numeric literal scanner: per-character classify, shift-add and phase update.
// Depends on nls_pkg and assert_macros.svh.
//
// Usage:
//   char channel: one source character a word (ch, first). first marks the
//   start of a literal; ch = 0 marks end of line and ends any literal.
//   tok channel: one token word when a literal ends: kind, radix, integer
//   part, fraction numerator, fraction digit count and replay, the count of
//   trailing characters the lexer must read again.
//   Token timing: the token for the terminating character is registered and
//   valid in the cycle after that character is accepted.
//   Throughput: one character a cycle while char_stall is low; all work
//   for a character is one pass through the classify and shift-add logic
//   into the state and token registers.
//   Stall: a token waiting under tok_stall holds the token register; the char
//   channel stalls only while that token is held, so one character can be
//   taken in the cycle the token drains.
//   Reset: phase returns to idle, accumulators clear, no token is valid.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module number_literal_scanner
  import nls_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_stall,
  input  char_word_t char_word,
  output logic       tok_valid,
  input  logic       tok_stall,
  output tok_word_t  tok_word
);

  localparam int VW = VALUE_WIDTH;

  phase_t          phase, phase_next;
  base_t           base_code, base_next;
  logic [VW-1:0]   int_acc, int_next;
  logic [VW-1:0]   frac_acc, frac_next;
  logic [7:0]      frac_count, count_next;

  logic            accept;
  logic            emit;
  kind_t           emit_kind;
  logic [1:0]      emit_replay;
  logic            do_int;
  logic            do_frac;
  logic [7:0]      c;
  logic [7:0]      dec_val;
  logic [4:0]      dig;
  logic [VW-1:0]   mac_in;
  logic [VW-1:0]   mac_out;
  tok_word_t       tok_next;

  assign c          = char_word.ch;
  assign dec_val    = c - CH_0;
  assign char_stall = tok_valid & tok_stall;
  assign accept     = char_valid & ~char_stall;
  assign dig        = digit_of(base_code, c);

  // acc * radix + digit, as shifts
  always_comb begin
    unique case (base_code)
      BASE_BIN: mac_out = mac_in << 1;
      BASE_OCT: mac_out = mac_in << 3;
      BASE_HEX: mac_out = mac_in << 4;
      default:  mac_out = (mac_in << 3) + (mac_in << 1);
    endcase
    mac_out = mac_out + {{(VW-4){1'b0}}, dig[3:0]};
  end

  assign mac_in = (phase == PH_DOT || phase == PH_FRAC) ? frac_acc : int_acc;

  always_comb begin
    phase_next  = phase;
    base_next   = base_code;
    int_next    = int_acc;
    frac_next   = frac_acc;
    count_next  = frac_count;
    emit        = 1'b0;
    emit_kind   = KIND_INT;
    emit_replay = REPLAY_ONE;
    do_int      = 1'b0;
    do_frac     = 1'b0;

    if (char_word.first) begin
      base_next  = BASE_DEC;
      int_next   = '0;
      frac_next  = '0;
      count_next = '0;
      if (is_dec(c) && c != CH_0) begin
        int_next   = {{(VW-4){1'b0}}, dec_val[3:0]};
        phase_next = PH_INT;
      end else if (c == CH_0) begin
        phase_next = PH_ZERO;
      end else if (c == CH_DOT) begin
        phase_next = PH_DOT;
      end else begin
        phase_next = PH_IDLE;
      end
    end else begin
      unique case (phase)
        PH_ZERO: begin
          phase_next = PH_INT;
          if (c == CH_B) base_next = BASE_BIN;
          else if (c == CH_O) base_next = BASE_OCT;
          else if (c == CH_D) base_next = BASE_DEC;
          else if (c == CH_X) base_next = BASE_HEX;
          else do_int = 1'b1;
        end
        PH_INT: do_int = 1'b1;
        PH_DOT: begin
          if (c == CH_DOT) begin
            emit        = 1'b1;
            emit_replay = REPLAY_TWO;
          end else begin
            phase_next = PH_FRAC;
            do_frac    = 1'b1;
          end
        end
        PH_FRAC: do_frac = 1'b1;
        PH_SKIP_INT: begin
          if (!is_alnum(c)) begin
            emit      = 1'b1;
            emit_kind = KIND_BAD_INT;
          end
        end
        PH_SKIP_FRAC: begin
          if (!is_alnum(c)) begin
            emit      = 1'b1;
            emit_kind = KIND_BAD_REAL;
          end
        end
        default: phase_next = PH_IDLE;
      endcase

      if (do_int && c != CH_UNDER) begin
        if (dig[4]) int_next = mac_out;
        else if (is_alnum(c)) phase_next = PH_SKIP_INT;
        else if (c == CH_DOT) phase_next = PH_DOT;
        else emit = 1'b1;
      end

      if (do_frac && c != CH_UNDER) begin
        if (dig[4]) begin
          frac_next = mac_out;
          if (frac_count != 8'hFF) count_next = frac_count + 8'd1;
        end else if (is_alnum(c)) begin
          phase_next = PH_SKIP_FRAC;
        end else begin
          emit      = 1'b1;
          emit_kind = KIND_REAL;
        end
      end

      if (emit) begin
        phase_next = PH_IDLE;
        base_next  = BASE_DEC;
        int_next   = '0;
        frac_next  = '0;
        count_next = '0;
      end
    end
  end

  always_comb begin
    tok_next.kind        = emit_kind;
    tok_next.radix       = radix_of(base_code);
    tok_next.int_value   = '0;
    tok_next.frac_value  = '0;
    tok_next.frac_places = '0;
    tok_next.replay      = emit_replay;
    if (emit_kind == KIND_INT || emit_kind == KIND_REAL) begin
      tok_next.int_value = 32'(signed'(int_acc));
    end
    if (emit_kind == KIND_REAL) begin
      tok_next.frac_value  = 32'(signed'(frac_acc));
      tok_next.frac_places = frac_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      base_code  <= BASE_DEC;
      int_acc    <= '0;
      frac_acc   <= '0;
      frac_count <= '0;
      tok_valid  <= 1'b0;
    end else begin
      if (accept) begin
        phase      <= phase_next;
        base_code  <= base_next;
        int_acc    <= int_next;
        frac_acc   <= frac_next;
        frac_count <= count_next;
      end
      if (accept && emit) begin
        tok_valid <= 1'b1;
      end else if (!tok_stall) begin
        tok_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      tok_word <= tok_next;
    end
  end

  `AST_NEXT(a_emit_idle, clk, rst, accept && emit,
            phase == PH_IDLE && base_code == BASE_DEC && int_acc == '0,
            "scanner not idle after a token")
  `AST_HOLDS(a_frac_phase, clk, rst,
             frac_count == 8'd0 || phase == PH_FRAC || phase == PH_SKIP_FRAC,
             "fraction count outside a fraction")
  `AST_HOLDS(a_idle_clear, clk, rst,
             phase != PH_IDLE || (base_code == BASE_DEC && frac_acc == '0),
             "idle with live accumulators")
  `AST_HOLDS(a_bad_zero, clk, rst,
             !tok_valid || tok_word.kind == KIND_INT || tok_word.kind == KIND_REAL ||
             (tok_word.int_value == 32'sd0 && tok_word.frac_value == 32'sd0),
             "malformed token carries a value")
  `AST_HOLDS(a_replay_int, clk, rst,
             !tok_valid || tok_word.replay != REPLAY_TWO ||
             (tok_word.kind == KIND_INT && tok_word.frac_places == 8'd0),
             "double dot ended a non-integer")

endmodule
